[rtl/core/frls_pkg.sv]
// Package for the FASTA record length scanner: byte codes and the byte classifier.
package frls_pkg;

    // Line separator bytes
    localparam logic [7:0] SEP_CR  = 8'h0D;
    localparam logic [7:0] SEP_LF  = 8'h0A;
    localparam logic [7:0] SEP_BOM0 = 8'hEF;
    localparam logic [7:0] SEP_BOM1 = 8'hBB;
    localparam logic [7:0] SEP_BOM2 = 8'hBF;

    // Header marker and the ">tag" prefix
    localparam logic [7:0] HDR_MARK = 8'h3E;
    localparam logic [3:0][7:0] TAG_PREFIX = {8'h67, 8'h61, 8'h74, 8'h3E};

    // A tag header is exactly this many bytes long
    localparam logic [2:0] TAG_HDR_LEN = 3'd5;
    localparam logic [2:0] HDR_LEN_MAX = 3'd7;
    localparam logic [2:0] PREFIX_LEN  = 3'd4;

    // Line separator check
    function automatic logic is_separator(input logic [7:0] b);
        return (b == SEP_CR) || (b == SEP_LF) || (b == SEP_BOM0) ||
               (b == SEP_BOM1) || (b == SEP_BOM2);
    endfunction

    // IUPAC base letter check (all but U), either case
    function automatic logic is_base(input logic [7:0] b);
        logic [7:0] up;
        logic       hit;
        up  = b & 8'hDF;
        hit = 1'b0;
        if (b[5] == 1'b1 || b[7:6] == 2'b01) begin
            unique case (up)
                8'h41, 8'h42, 8'h43, 8'h44, 8'h47, 8'h48, 8'h4B, 8'h4D,
                8'h4E, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h59: hit = 1'b1;
                default: hit = 1'b0;
            endcase
        end
        return hit && (b[7:6] == 2'b01);
    endfunction

endpackage

[rtl/core/fasta_record_length_scanner.sv]
// FASTA record length scanner: counts primer and tag records and their lengths.
// The result word is registered; it appears on the master side in the cycle after the last byte.
// Throughput: one byte per clock; the state update is a single pass of logic.
// A last byte is held off only while an earlier result still waits at the output.
// Reset (i_rst_n low, synchronous) clears all counters and the output valid;
// after each result the scanner also returns to its reset state.
module fasta_record_length_scanner #(
    parameter int unsigned COUNT_WIDTH  = 16,
    parameter int unsigned LENGTH_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,   // end_of_file
    // Result out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [15:0] primer_total, [31:16] tag_total,
                                          // [47:32] shortest_primer,
                                          // [63:48] longest_tagged, [79:64] longest_tag
    output logic        o_m_axis_tuser    // no_sequences
);
    import frls_pkg::*;

    localparam logic [COUNT_WIDTH-1:0]  CNT_MAX = '1;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    // Scan state
    logic                    r_in_line,     n_in_line;
    logic                    r_is_header,   n_is_header;
    logic [2:0]              r_hdr_len,     n_hdr_len;
    logic                    r_hdr_match,   n_hdr_match;
    logic                    r_rec_open,    n_rec_open;
    logic                    r_tag_mode,    n_tag_mode;
    logic [LENGTH_WIDTH-1:0] r_base_cnt,    n_base_cnt;
    logic [COUNT_WIDTH-1:0]  r_primer_cnt,  n_primer_cnt;
    logic [COUNT_WIDTH-1:0]  r_tag_cnt,     n_tag_cnt;
    logic [LENGTH_WIDTH-1:0] r_min_len,     n_min_len;
    logic [LENGTH_WIDTH-1:0] r_max_len,     n_max_len;
    logic [LENGTH_WIDTH-1:0] r_max_tag,     n_max_tag;

    // Output register
    logic        r_out_valid;
    logic [79:0] r_out_data,  n_out_data;
    logic        r_out_none,  n_out_none;

    logic       in_fire;
    logic [7:0] byte_in;
    logic       sep_hit;
    logic       base_hit;
    logic       close_en;
    logic [LENGTH_WIDTH:0] long_sum;
    logic [LENGTH_WIDTH-1:0] long_sat;

    assign byte_in  = i_s_axis_tdata;
    assign sep_hit  = is_separator(byte_in);
    assign base_hit = is_base(byte_in);

    // Only a last byte must wait for the output register to free up
    assign o_s_axis_tready = !(r_out_valid && !i_m_axis_tready && i_s_axis_tlast);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    // Per-byte state update and record close
    always_comb begin
        n_in_line    = r_in_line;
        n_is_header  = r_is_header;
        n_hdr_len    = r_hdr_len;
        n_hdr_match  = r_hdr_match;
        n_rec_open   = r_rec_open;
        n_tag_mode   = r_tag_mode;
        n_base_cnt   = r_base_cnt;
        n_primer_cnt = r_primer_cnt;
        n_tag_cnt    = r_tag_cnt;
        n_min_len    = r_min_len;
        n_max_len    = r_max_len;
        n_max_tag    = r_max_tag;
        close_en     = 1'b0;

        // Line structure
        if (sep_hit) begin
            if (r_in_line && r_is_header) begin
                n_tag_mode = r_hdr_match && (r_hdr_len == TAG_HDR_LEN);
            end
            n_in_line = 1'b0;
        end else if (!r_in_line) begin
            n_in_line = 1'b1;
            if (byte_in == HDR_MARK) begin
                close_en    = 1'b1;
                n_is_header = 1'b1;
                n_hdr_len   = 3'd1;
                n_hdr_match = 1'b1;
            end else begin
                n_is_header = 1'b0;
                if (!r_rec_open) begin
                    n_rec_open = 1'b1;
                    n_base_cnt = '0;
                end
                if (base_hit && n_base_cnt != LEN_MAX) begin
                    n_base_cnt = n_base_cnt + LENGTH_WIDTH'(1);
                end
            end
        end else if (r_is_header) begin
            if (r_hdr_len < PREFIX_LEN && byte_in != TAG_PREFIX[r_hdr_len[1:0]]) begin
                n_hdr_match = 1'b0;
            end
            if (r_hdr_len < HDR_LEN_MAX) begin
                n_hdr_len = r_hdr_len + 3'd1;
            end
        end else if (base_hit && r_base_cnt != LEN_MAX) begin
            n_base_cnt = r_base_cnt + LENGTH_WIDTH'(1);
        end

        // Close the open record on a new header or on the last byte
        if ((close_en || i_s_axis_tlast) && n_rec_open) begin
            if (n_tag_mode) begin
                if (r_tag_cnt != CNT_MAX) begin
                    n_tag_cnt = r_tag_cnt + COUNT_WIDTH'(1);
                end
                if (n_base_cnt > r_max_tag) begin
                    n_max_tag = n_base_cnt;
                end
            end else begin
                if (r_primer_cnt == '0 || n_base_cnt < r_min_len) begin
                    n_min_len = n_base_cnt;
                end
                if (n_base_cnt > r_max_len) begin
                    n_max_len = n_base_cnt;
                end
                if (r_primer_cnt != CNT_MAX) begin
                    n_primer_cnt = r_primer_cnt + COUNT_WIDTH'(1);
                end
            end
            n_rec_open = 1'b0;
            n_base_cnt = '0;
        end
    end

    // Result word from the post-close totals
    assign long_sum = {1'b0, n_max_len} + {1'b0, n_max_tag};
    assign long_sat = long_sum[LENGTH_WIDTH] ? LEN_MAX : long_sum[LENGTH_WIDTH-1:0];

    always_comb begin
        n_out_data[15:0]  = 16'(32'(n_primer_cnt));
        n_out_data[31:16] = 16'(32'(n_tag_cnt));
        n_out_data[47:32] = (n_primer_cnt != '0) ? 16'(32'(n_min_len)) : 16'd0;
        n_out_data[63:48] = 16'(32'(long_sat));
        n_out_data[79:64] = 16'(32'(n_max_tag));
        n_out_none        = (n_primer_cnt == '0);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_line    <= 1'b0;
            r_is_header  <= 1'b0;
            r_hdr_len    <= '0;
            r_hdr_match  <= 1'b0;
            r_rec_open   <= 1'b0;
            r_tag_mode   <= 1'b0;
            r_base_cnt   <= '0;
            r_primer_cnt <= '0;
            r_tag_cnt    <= '0;
            r_min_len    <= '0;
            r_max_len    <= '0;
            r_max_tag    <= '0;
        end else if (in_fire) begin
            if (i_s_axis_tlast) begin
                // back to the reset state for the next file
                r_in_line    <= 1'b0;
                r_is_header  <= 1'b0;
                r_hdr_len    <= '0;
                r_hdr_match  <= 1'b0;
                r_rec_open   <= 1'b0;
                r_tag_mode   <= 1'b0;
                r_base_cnt   <= '0;
                r_primer_cnt <= '0;
                r_tag_cnt    <= '0;
                r_min_len    <= '0;
                r_max_len    <= '0;
                r_max_tag    <= '0;
            end else begin
                r_in_line    <= n_in_line;
                r_is_header  <= n_is_header;
                r_hdr_len    <= n_hdr_len;
                r_hdr_match  <= n_hdr_match;
                r_rec_open   <= n_rec_open;
                r_tag_mode   <= n_tag_mode;
                r_base_cnt   <= n_base_cnt;
                r_primer_cnt <= n_primer_cnt;
                r_tag_cnt    <= n_tag_cnt;
                r_min_len    <= n_min_len;
                r_max_len    <= n_max_len;
                r_max_tag    <= n_max_tag;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_s_axis_tlast) begin
            r_out_data <= n_out_data;
            r_out_none <= n_out_none;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_none;

endmodule

[sim/fasta_record_length_scanner_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the FASTA record length scanner: byte stream in, file totals out.
import frls_pkg::*;

// One result word as the block sends it: tdata in bits 79:0, tuser on top
typedef struct packed {
    logic        no_sequences;
    logic [15:0] longest_tag;
    logic [15:0] longest_tagged;
    logic [15:0] shortest_primer;
    logic [15:0] tag_total;
    logic [15:0] primer_total;
} file_totals_t;

// Tracks the scan of the text and holds the totals each file should produce
class record_totals_sb;
    bit           in_line;
    bit           line_is_hdr;
    bit           prefix_ok;
    bit           rec_open;
    bit           tag_mode;
    bit [2:0]     hdr_len;
    bit [15:0]    base_cnt;
    bit [15:0]    primer_cnt;
    bit [15:0]    tag_cnt;
    bit [15:0]    min_len;
    bit [15:0]    max_len;
    bit [15:0]    max_tag_len;
    file_totals_t totals_due[$];
    int           errors;
    int           checked;

    function new();
        clear_scan();
        errors  = 0;
        checked = 0;
    endfunction

    function void clear_scan();
        in_line     = 1'b0;
        line_is_hdr = 1'b0;
        prefix_ok   = 1'b0;
        rec_open    = 1'b0;
        tag_mode    = 1'b0;
        hdr_len     = '0;
        base_cnt    = '0;
        primer_cnt  = '0;
        tag_cnt     = '0;
        min_len     = '0;
        max_len     = '0;
        max_tag_len = '0;
    endfunction

    function bit sep_byte(bit [7:0] b);
        return b == SEP_CR || b == SEP_LF || b == SEP_BOM0 || b == SEP_BOM1 || b == SEP_BOM2;
    endfunction

    // IUPAC letters (all but U), both cases
    function bit base_byte(bit [7:0] b);
        case (b)
            "A", "B", "C", "D", "G", "H", "K", "M", "N", "R", "S", "T", "V", "W", "Y",
            "a", "b", "c", "d", "g", "h", "k", "m", "n", "r", "s", "t", "v", "w", "y":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function bit [15:0] sat_inc(bit [15:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    function void count_base(bit [7:0] b);
        if (base_byte(b)) base_cnt = sat_inc(base_cnt);
    endfunction

    // Fold the open record into the tag or primer statistics
    function void close_record();
        if (!rec_open) return;
        if (tag_mode) begin
            tag_cnt = sat_inc(tag_cnt);
            if (base_cnt > max_tag_len) max_tag_len = base_cnt;
        end else begin
            if (primer_cnt == 16'd0 || base_cnt < min_len) min_len = base_cnt;
            if (base_cnt > max_len) max_len = base_cnt;
            primer_cnt = sat_inc(primer_cnt);
        end
        rec_open = 1'b0;
        base_cnt = '0;
    endfunction

    // Advance the scan by one accepted byte; a last byte queues the file totals
    function void note_word(bit [7:0] b, bit last);
        bit [16:0]    sum;
        file_totals_t t;
        if (sep_byte(b)) begin
            if (in_line && line_is_hdr) tag_mode = prefix_ok && (hdr_len == TAG_HDR_LEN);
            in_line = 1'b0;
        end else if (!in_line) begin
            in_line = 1'b1;
            if (b == HDR_MARK) begin
                close_record();
                line_is_hdr = 1'b1;
                hdr_len     = 3'd1;
                prefix_ok   = 1'b1;
            end else begin
                line_is_hdr = 1'b0;
                if (!rec_open) begin
                    rec_open = 1'b1;
                    base_cnt = '0;
                end
                count_base(b);
            end
        end else if (line_is_hdr) begin
            if (hdr_len < PREFIX_LEN && b != TAG_PREFIX[hdr_len[1:0]]) prefix_ok = 1'b0;
            if (hdr_len < HDR_LEN_MAX) hdr_len = hdr_len + 3'd1;
        end else begin
            count_base(b);
        end

        if (!last) return;
        close_record();
        sum = {1'b0, max_len} + {1'b0, max_tag_len};
        t.primer_total    = primer_cnt;
        t.tag_total       = tag_cnt;
        t.shortest_primer = (primer_cnt != 16'd0) ? min_len : 16'd0;
        t.longest_tagged  = sum[16] ? 16'hFFFF : sum[15:0];
        t.longest_tag     = max_tag_len;
        t.no_sequences    = (primer_cnt == 16'd0);
        totals_due.push_back(t);
        clear_scan();
    endfunction

    function void check_field(string name, bit [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // Compare one accepted result word with the oldest pending totals
    function void check_result(logic [79:0] data, logic user);
        file_totals_t got;
        file_totals_t want;
        got = {user, data};
        if (totals_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual %h/%b",
                     $time, data, user);
            return;
        end
        want = totals_due.pop_front();
        checked++;
        check_field("primer_total", want.primer_total, got.primer_total);
        check_field("tag_total", want.tag_total, got.tag_total);
        check_field("shortest_primer", want.shortest_primer, got.shortest_primer);
        check_field("longest_tagged", want.longest_tagged, got.longest_tagged);
        check_field("longest_tag", want.longest_tag, got.longest_tag);
        check_field("no_sequences", {15'd0, want.no_sequences}, {15'd0, got.no_sequences});
    endfunction
endclass

module fasta_record_length_scanner_tb;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;
    logic        m_tuser;

    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          cycles        = 0;
    int          bytes_sent    = 0;
    int          files_sent    = 0;
    logic [7:0]  file_bytes[$];
    string       base_chars    = "ABCDGHKMNRSTVWYabcdghkmnrstvwy";
    record_totals_sb sb;

    fasta_record_length_scanner u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check accepted words, stall at random
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Offer one byte, with random gaps ahead of it, and wait for the handshake
    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_word(b, last);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_word(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
        files_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
    endtask

    // Any byte that does not end a line
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (sb.sep_byte(b));
        return b;
    endfunction

    task automatic push_sep_run();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(4))
                0: file_bytes.push_back(SEP_CR);
                1: file_bytes.push_back(SEP_LF);
                2: file_bytes.push_back(SEP_BOM0);
                3: file_bytes.push_back(SEP_BOM1);
                default: file_bytes.push_back(SEP_BOM2);
            endcase
        end
    endtask

    // Tag headers, near misses and plain headers of assorted lengths
    task automatic push_header();
        int n;
        int k;
        n = $urandom_range(0, 8);
        case ($urandom_range(5))
            0, 1: begin
                push_text(">tag");
                file_bytes.push_back(text_byte());
            end
            2: push_text(">tag");
            3: begin
                push_text(">tag");
                repeat ($urandom_range(2, 4)) file_bytes.push_back(text_byte());
            end
            4: begin
                file_bytes.push_back(HDR_MARK);
                repeat (n) file_bytes.push_back(text_byte());
            end
            default: begin
                // five bytes with one prefix letter spoiled
                k = $urandom_range(1, 3);
                push_text(">tag");
                file_bytes[file_bytes.size() - 4 + k] = text_byte();
                file_bytes.push_back(text_byte());
            end
        endcase
    endtask

    task automatic push_data_line();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) begin
            if ($urandom_range(99) < 80)
                file_bytes.push_back(base_chars[$urandom_range(base_chars.len() - 1)]);
            else
                file_bytes.push_back(text_byte());
        end
    endtask

    // Mostly well-formed files of random content, some pure noise
    task automatic build_random_file();
        int lines;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom_range(255)));
        end else begin
            lines = $urandom_range(1, 6);
            if ($urandom_range(99) < 30) push_sep_run();
            for (int i = 0; i < lines; i++) begin
                if ($urandom_range(99) < 35) push_header();
                else push_data_line();
                if (i < lines - 1 || $urandom_range(1)) push_sep_run();
            end
        end
    endtask

    task automatic run_random(input int min_bytes);
        int first_byte;
        int first_file;
        first_byte = bytes_sent;
        first_file = files_sent;
        while (bytes_sent - first_byte < min_bytes || files_sent - first_file < 15) begin
            build_random_file();
            send_file();
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: light source gaps, heavy sink stalls
        src_idle_pct  = 13;
        sink_idle_pct = 86;

        // Lone zero byte: an empty record
        file_bytes.push_back(8'h00);
        send_file();
        // Tag header cut off by the end of the file
        push_text(">tag1");
        send_file();
        // All separators, a tag record, a bare header, 0xFF and a record closed by the end
        push_text(">tagQ");
        file_bytes.push_back(SEP_BOM0);
        push_text("ac");
        file_bytes.push_back(SEP_CR);
        file_bytes.push_back(SEP_LF);
        file_bytes.push_back(HDR_MARK);
        file_bytes.push_back(SEP_BOM1);
        file_bytes.push_back("N");
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(SEP_BOM2);
        file_bytes.push_back("t");
        send_file();

        run_random(500);

        // Phase 2: the other way round
        src_idle_pct  = 86;
        sink_idle_pct = 13;
        run_random(500);

        // Phase 3: full rate both ways
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(500);
        s_tvalid <= 1'b0;

        while (sb.totals_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Scanned %0d bytes in %0d files, %0d result words checked, %0d mismatches",
                 bytes_sent, files_sent, sb.checked, sb.errors);
        $display("Covered tag and broken headers, noise bytes, gaps and stalls");
        if (sb.errors == 0 && sb.totals_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
